>>> hw/rtl/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types and constants for the HTTP body deframer.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 48;
  localparam int CFG_ADDR_W      = 1;
  localparam int CFG_DATA_W      = LEN_W;
  localparam int MODE_W          = 2;
  localparam int PHASE_W         = 2;
  localparam int SKIP_W          = 2;

  localparam int HEADER_KEEP_DEF = 32;
  localparam int COUNT_BITS_DEF  = 48;

  // body modes; the unused code falls through to stream mode
  localparam logic [MODE_W-1:0] MODE_CHUNKED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LENGTH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STREAM  = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_BODY_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_BODY_LEN  = 1'b1;

  // chunked-mode phases
  localparam logic [PHASE_W-1:0] PH_HEADER = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DATA   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SKIP   = 2'd2;

  localparam logic [SKIP_W-1:0] SKIP_CLOSE = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0a;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [SKIP_W-1:0]  skip_left;
    logic               in_number;
    logic               saw_digit;
  } chunk_ctl_t;

  typedef struct packed {
    logic has_data;
    logic finish;
  } chunk_res_t;

endpackage

>>> hw/rtl/hbd_chunk.sv
// ----------------------------------------------------------------------------
// hbd_chunk
// Next-state logic for chunked transfer: size line, chunk data, closing bytes.
// ----------------------------------------------------------------------------
module hbd_chunk #(
  parameter int HEADER_KEEP = hbd_pkg::HEADER_KEEP_DEF,
  parameter int COUNT_BITS  = hbd_pkg::COUNT_BITS_DEF,
  localparam int KEPT_W     = $clog2(HEADER_KEEP + 1)
) (
  input  logic [hbd_pkg::BYTE_W-1:0] byte_i,
  input  hbd_pkg::chunk_ctl_t        ctl_i,
  input  logic [COUNT_BITS-1:0]      count_i,
  input  logic [KEPT_W-1:0]          kept_i,
  output hbd_pkg::chunk_ctl_t        ctl_o,
  output logic [COUNT_BITS-1:0]      count_o,
  output logic [KEPT_W-1:0]          kept_o,
  output hbd_pkg::chunk_res_t        res_o
);
  import hbd_pkg::*;

  logic                  hex_ok;
  logic [3:0]            hex_val;
  logic [COUNT_BITS-1:0] count_dec;
  logic [SKIP_W-1:0]     skip_dec;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (byte_i >= "0" && byte_i <= "9") begin
      hex_val = 4'(byte_i - "0");
    end else if (byte_i >= "a" && byte_i <= "f") begin
      hex_val = 4'(byte_i - "a" + 8'd10);
    end else if (byte_i >= "A" && byte_i <= "F") begin
      hex_val = 4'(byte_i - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign count_dec = count_i - COUNT_BITS'(1);
  assign skip_dec  = (ctl_i.skip_left != '0) ? ctl_i.skip_left - SKIP_W'(1) : ctl_i.skip_left;

  always_comb begin
    ctl_o   = ctl_i;
    count_o = count_i;
    kept_o  = kept_i;
    res_o   = '0;
    case (ctl_i.phase)
      PH_DATA: begin
        res_o.has_data = 1'b1;
        count_o        = count_dec;
        if (count_dec == '0) begin
          ctl_o.phase     = PH_SKIP;
          ctl_o.skip_left = SKIP_CLOSE;
        end
      end
      PH_SKIP: begin
        ctl_o.skip_left = skip_dec;
        if (skip_dec == '0) ctl_o.phase = PH_HEADER;
      end
      default: begin
        if (byte_i == CHAR_LF) begin
          if (!ctl_i.saw_digit || count_i == '0) begin
            res_o.finish = 1'b1;
          end else begin
            ctl_o.phase = PH_DATA;
          end
          kept_o          = '0;
          ctl_o.in_number = 1'b1;
          ctl_o.saw_digit = 1'b0;
        end else if (byte_i != CHAR_CR && kept_i < KEPT_W'(HEADER_KEEP)) begin
          kept_o = kept_i + KEPT_W'(1);
          if (ctl_i.in_number) begin
            if (!hex_ok) begin
              ctl_o.in_number = 1'b0;
            end else begin
              // a non-zero top nibble means the next digit overflows: saturate
              if (count_i[COUNT_BITS-1 -: 4] != 4'd0) begin
                count_o = '1;
              end else begin
                count_o = {count_i[COUNT_BITS-5:0], hex_val};
              end
              ctl_o.saw_digit = 1'b1;
            end
          end
        end
      end
    endcase
  end

endmodule

>>> hw/rtl/hbd_out_reg.sv
// ----------------------------------------------------------------------------
// hbd_out_reg
// Result register on the master side; holds a transaction until it is taken.
// ----------------------------------------------------------------------------
module hbd_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load_i,
  input  logic [hbd_pkg::BYTE_W-1:0] byte_i,
  input  logic                       has_i,
  input  logic                       done_i,
  output logic                       free_o,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [hbd_pkg::BYTE_W-1:0] out_tdata,
  output logic [1:0]                 out_tuser
);
  import hbd_pkg::*;

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;
  logic [1:0]        user_r;

  assign free_o = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      byte_r <= byte_i;
      user_r <= {done_i, has_i};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = user_r;

endmodule

>>> hw/rtl/http_body_deframer.sv
// ----------------------------------------------------------------------------
// http_body_deframer
// Strips HTTP body framing: chunked, fixed content length or until end.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  in_*     | slave     | one raw body byte or the end-of-stream marker
//  out_*    | master    | one result per input: payload byte and flags
//  cfg_*    | write     | body_mode (index 0), body length (index 1)
//
// One byte per cycle sustained while results are taken; each transaction
// passes the input register and then the result register, where it is
// presented until it is taken.
// The state update is a single pass of the chunk next-state logic.
// Synchronous reset; no clearing pass is needed.
// A stalled result register holds the input register, which then drops
// in_tready; nothing is lost.
// ----------------------------------------------------------------------------
module http_body_deframer #(
  parameter int HEADER_KEEP = hbd_pkg::HEADER_KEEP_DEF,
  parameter int COUNT_BITS  = hbd_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hbd_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] raw_byte
  input  logic                           in_tlast,   // stream_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [hbd_pkg::BYTE_W-1:0]     out_tdata,  // [7:0] payload_byte
  output logic [1:0]                     out_tuser,  // [0] has_data, [1] body_done
  input  logic                           cfg_we,
  input  logic [hbd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hbd_pkg::*;

  localparam int KEPT_W = $clog2(HEADER_KEEP + 1);

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_end_r;

  logic [MODE_W-1:0]     mode_r;
  logic [LEN_W-1:0]      length_left_r;
  logic [LEN_W-1:0]      length_left_nxt;
  chunk_ctl_t            ctl_r;
  chunk_ctl_t            ctl_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic [KEPT_W-1:0]     kept_r;
  logic [KEPT_W-1:0]     kept_nxt;
  logic                  finished_r;
  logic                  finished_nxt;

  chunk_res_t        chunk_res;
  logic              out_free;
  logic              advance;
  logic              chunk_step;
  logic              res_has;
  logic [BYTE_W-1:0] res_byte;

  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  hbd_chunk #(
    .HEADER_KEEP(HEADER_KEEP),
    .COUNT_BITS (COUNT_BITS)
  ) u_chunk (
    .byte_i (in_byte_r),
    .ctl_i  (ctl_r),
    .count_i(count_r),
    .kept_i (kept_r),
    .ctl_o  (ctl_nxt),
    .count_o(count_nxt),
    .kept_o (kept_nxt),
    .res_o  (chunk_res)
  );

  always_comb begin
    chunk_step      = 1'b0;
    res_has         = 1'b0;
    finished_nxt    = finished_r;
    length_left_nxt = length_left_r;
    if (!finished_r) begin
      if (in_end_r) begin
        finished_nxt = 1'b1;
      end else begin
        case (mode_r)
          MODE_CHUNKED: begin
            chunk_step   = 1'b1;
            res_has      = chunk_res.has_data;
            finished_nxt = chunk_res.finish;
          end
          MODE_LENGTH: begin
            if (length_left_r == '0) begin
              finished_nxt = 1'b1;
            end else begin
              res_has         = 1'b1;
              length_left_nxt = length_left_r - LEN_W'(1);
            end
          end
          default: begin
            res_has = 1'b1;
          end
        endcase
      end
    end
  end

  assign res_byte = res_has ? in_byte_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_CHUNKED;
      length_left_r <= '0;
      ctl_r         <= '{phase: PH_HEADER, skip_left: '0, in_number: 1'b1, saw_digit: 1'b0};
      count_r       <= '0;
      kept_r        <= '0;
      finished_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BODY_MODE: mode_r        <= cfg_wdata[MODE_W-1:0];
        REG_BODY_LEN:  length_left_r <= cfg_wdata[LEN_W-1:0];
      endcase
    end else if (advance) begin
      finished_r    <= finished_nxt;
      length_left_r <= length_left_nxt;
      if (chunk_step) begin
        ctl_r   <= ctl_nxt;
        count_r <= count_nxt;
        kept_r  <= kept_nxt;
      end
    end
  end

  hbd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (advance),
    .byte_i    (res_byte),
    .has_i     (res_has),
    .done_i    (finished_nxt),
    .free_o    (out_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

>>> hw/rtl/hbd_checker.sv
// ----------------------------------------------------------------------------
// hbd_checker
// Port-level checks for the HTTP body deframer, bound to the top level.
// ----------------------------------------------------------------------------
module hbd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [hbd_pkg::BYTE_W-1:0] out_tdata,
  input logic [1:0]                 out_tuser
);
  import hbd_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no payload byte means a zero data field
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("data without has_data flag");

  // a delivered byte never coincides with the finished body
  a_has_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("payload byte after body end");

  // input stalls only behind a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result register");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind http_body_deframer hbd_checker u_hbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
